### rtl/core/pmfb_pkg.sv
package pmfb_pkg;

  typedef enum logic [2:0] {
    OP_ERASE = 3'd0,
    OP_PIXEL = 3'd1,
    OP_HLINE = 3'd2,
    OP_VLINE = 3'd3,
    OP_CHAR  = 3'd4,
    OP_FONTW = 3'd5,
    OP_READ  = 3'd6,
    OP_UNDEF = 3'd7
  } op_e;

  localparam logic [1:0] CFG_GLYPH_COUNT  = 2'd0;
  localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd2;

  localparam logic [7:0] CHAR_BASE = 8'h20;

  // Frame address width that covers the largest supported screen.
  localparam int unsigned FRAME_AW = 13;

  // Frame store access request from the sequencer.
  typedef struct packed {
    logic                rd;
    logic                wr;
    logic [FRAME_AW-1:0] addr;
    logic [7:0]          wdata;
  } mem_req_t;

endpackage

### rtl/core/pmfb_frame_mem.sv
module pmfb_frame_mem #(
  parameter int unsigned Depth = 800,
  parameter int unsigned AW = 10
) (
  input  logic                  clk_i,
  input  pmfb_pkg::mem_req_t    req_i,
  output logic [7:0]            rdata_o
);
  import pmfb_pkg::*;

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_o <= mem_q[req_i.addr[AW-1:0]];
    end
  end

endmodule

### rtl/core/pmfb_font_mem.sv
module pmfb_font_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          wr_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          rd_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/core/paged_mono_framebuffer_draw_top.sv
// Drawing engine over a page-organized monochrome framebuffer: each byte holds
// eight vertical pixels, byte index (y/8)*SCREEN_WIDTH + x. Raise start with
// a command while busy is low; busy rises at once and the result appears
// on done_o for exactly one cycle, which the receiver must take as it comes.
// Every drawn pixel is one read-modify-write of the frame memory through its
// single port, whose read data is registered. A font write, an undefined
// command, a line with on low or a glyph outside the font goes straight to
// the result; a byte read first waits for its registered read data, and a
// pixel is checked and, when it lands on the screen, read, waited on and
// written. A line or glyph pixel takes the steps select, check, read, wait
// and write when it lands on the screen, and only select and check when it
// is clipped; a glyph adds a font fetch and a column step per column; a walk
// ends with a final step before the result. An erase writes every
// framebuffer byte before the result. The longest commands are a 255-pixel
// line and a 15 by 15 glyph. busy falls in the cycle that carries done_o,
// so the next command can be taken at the edge that ends it.
// After reset a clearing pass writes zero to all SCREEN_WIDTH*pages bytes, one
// per cycle, with busy high; configuration writes are taken during it.
module paged_mono_framebuffer_draw_top #(
  parameter int unsigned SCREEN_WIDTH  = 100,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned FONT_BYTES    = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic        on_i,
  input  logic [7:0]  x_first_i,
  input  logic [7:0]  y_first_i,
  input  logic [7:0]  x_second_i,
  input  logic [7:0]  y_second_i,
  input  logic [9:0]  font_address_i,
  input  logic [7:0]  font_byte_i,
  input  logic [9:0]  frame_address_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        ignored_o
);
  import pmfb_pkg::*;

  localparam int unsigned Pages = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned FrameBytes = SCREEN_WIDTH * Pages;
  localparam int unsigned FAW = $clog2(FONT_BYTES);
  localparam int unsigned MAW = $clog2(FrameBytes);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PIX_CHK, S_RD, S_WAIT, S_WR, S_NEXT,
    S_FRD, S_FWAIT, S_DONE
  } state_e;

  state_e     state_q;
  logic [7:0] gcount_q;
  logic [3:0] gwidth_q, gheight_q;
  op_e        op_q;
  logic       on_q, ign_q, any_q;
  logic [7:0] rdata_q;
  logic [7:0] px_q, py_q;     // current pixel
  logic [8:0] cnt_q, end_q;   // line walk, exclusive end (9 bits)
  logic [3:0] col_q, row_q;
  logic [7:0] xb_q, yb_q;
  logic [7:0] fdata_q;
  logic       pset_q;
  logic [15:0] faddr_q;       // item * width + col
  logic [MAW:0] clr_q;
  mem_req_t   req;
  logic [7:0] mem_rd;
  logic [7:0] font_rd;
  logic       font_wr, font_rd_en;

  // Pixel address: page * width + x.
  logic        pix_on;
  logic [15:0] pix_addr;
  assign pix_on = (32'(px_q) < SCREEN_WIDTH) && (32'(py_q) < SCREEN_HEIGHT);
  assign pix_addr = 16'(32'(py_q[7:3]) * SCREEN_WIDTH + 32'(px_q));

  logic [7:0] item;
  assign item = x_second_i - CHAR_BASE;

  // Line span of the incoming command, ends put in order.
  logic       line_op;
  logic [7:0] line_a, line_b, line_lo, line_hi;
  assign line_op = (op_e'(operation_i) == OP_HLINE) || (op_e'(operation_i) == OP_VLINE);
  assign line_a  = (op_e'(operation_i) == OP_HLINE) ? x_first_i : y_first_i;
  assign line_b  = (op_e'(operation_i) == OP_HLINE) ? x_second_i : y_second_i;
  assign line_lo = (line_a > line_b) ? line_b : line_a;
  assign line_hi = (line_a > line_b) ? line_a : line_b;

  logic read_ok;
  assign read_ok = 32'(frame_address_i) < FrameBytes;

  always_comb begin
    req = '0;
    req.addr = pix_addr[FRAME_AW-1:0];
    if (state_q == S_CLEAR) begin
      req.wr = 1'b1;
      req.addr = FRAME_AW'(clr_q);
    end else if (state_q == S_RD) begin
      req.rd = 1'b1;
    end else if (state_q == S_WR) begin
      req.wr = 1'b1;
      req.wdata = pset_q ? (mem_rd | (8'd1 << py_q[2:0]))
                         : (mem_rd & ~(8'd1 << py_q[2:0]));
    end else if (state_q == S_IDLE && start && op_e'(operation_i) == OP_READ && read_ok) begin
      req.rd = 1'b1;
      req.addr = FRAME_AW'(frame_address_i);
    end
  end

  assign font_wr = (state_q == S_IDLE) && start && op_e'(operation_i) == OP_FONTW
                   && 32'(font_address_i) < FONT_BYTES;
  assign font_rd_en = (state_q == S_FRD);

  pmfb_frame_mem #(.Depth(FrameBytes), .AW(MAW)) u_frame (
    .clk_i, .req_i(req), .rdata_o(mem_rd)
  );

  pmfb_font_mem #(.Depth(FONT_BYTES), .AW(FAW)) u_font (
    .clk_i, .wr_i(font_wr), .waddr_i(FAW'(font_address_i)),
    .wdata_i(font_byte_i), .rd_i(font_rd_en), .raddr_i(faddr_q[FAW-1:0]),
    .rdata_o(font_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcount_q  <= 8'd0;
      gwidth_q  <= 4'd6;
      gheight_q <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GLYPH_COUNT:  gcount_q  <= cfg_data_i;
        CFG_GLYPH_WIDTH:  gwidth_q  <= cfg_data_i[3:0];
        CFG_GLYPH_HEIGHT: gheight_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_o  <= 1'b0;
      op_q    <= OP_UNDEF;
      on_q <= 1'b0; ign_q <= 1'b0; any_q <= 1'b0; rdata_q <= '0;
      px_q <= '0; py_q <= '0; cnt_q <= '0; end_q <= '0;
      col_q <= '0; row_q <= '0; xb_q <= '0; yb_q <= '0;
      fdata_q <= '0; pset_q <= 1'b0; faddr_q <= '0;
      read_data_o <= '0; ignored_o <= 1'b0;
    end else begin
      done_o <= (state_q == S_DONE);
      unique case (state_q)
        S_CLEAR: begin
          // The pass after reset returns to idle; an erase command reports.
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == FrameBytes - 1) begin
            state_q <= (op_q == OP_ERASE) ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q <= op_e'(operation_i);
            on_q <= on_i;
            rdata_q <= '0;
            any_q <= 1'b0;
            pset_q <= on_i || line_op;
            px_q <= x_first_i;
            py_q <= y_first_i;
            xb_q <= x_first_i;
            yb_q <= y_first_i;
            col_q <= '0;
            row_q <= '0;
            faddr_q <= 16'(item) * 16'(gwidth_q);
            cnt_q <= {1'b0, line_lo};
            end_q <= {1'b0, line_hi};
            unique case (op_e'(operation_i))
              OP_ERASE: begin
                clr_q <= '0;
                ign_q <= 1'b0;
                state_q <= S_CLEAR;
              end
              OP_PIXEL: begin
                ign_q <= 1'b0;
                state_q <= S_PIX_CHK;
              end
              OP_HLINE, OP_VLINE: begin
                // A line counts as ignored until one of its pixels lands.
                ign_q <= 1'b1;
                state_q <= on_i ? S_NEXT : S_DONE;
              end
              OP_CHAR: begin
                ign_q <= (item >= gcount_q);
                state_q <= (item >= gcount_q) ? S_DONE : S_NEXT;
              end
              OP_FONTW: begin
                ign_q <= !(32'(font_address_i) < FONT_BYTES);
                state_q <= S_DONE;
              end
              OP_READ: begin
                ign_q <= !read_ok;
                state_q <= read_ok ? S_WAIT : S_DONE;
              end
              default: begin
                ign_q <= 1'b1;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_PIX_CHK: begin
          // Off-screen pixels of a walk are dropped quietly; a pixel that
          // lands clears the line's ignored flag.
          if (pix_on) begin
            state_q <= S_RD;
            if (op_q == OP_HLINE || op_q == OP_VLINE) ign_q <= 1'b0;
          end else if (op_q == OP_PIXEL) begin
            ign_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_RD: state_q <= S_WAIT;
        S_WAIT: begin
          if (op_q == OP_READ) begin
            rdata_q <= mem_rd;
            state_q <= S_DONE;
          end else state_q <= S_WR;
        end
        S_WR: state_q <= (op_q == OP_PIXEL) ? S_DONE : S_NEXT;
        S_NEXT: begin
          // Pick the next pixel of a line or glyph.
          if (op_q == OP_CHAR) begin
            if (row_q == 4'd0 && !(col_q < gwidth_q)) state_q <= S_DONE;
            else if (row_q == 4'd0 && !any_q) begin
              any_q <= 1'b1;
              state_q <= S_FRD;
            end else if (row_q == gheight_q) begin
              row_q <= '0;
              col_q <= col_q + 1'b1;
              faddr_q <= faddr_q + 1'b1;
              any_q <= 1'b0;
            end else begin
              px_q <= xb_q + 8'(col_q);
              py_q <= yb_q + 8'(row_q);
              pset_q <= ((row_q < 4'd8) ? fdata_q[row_q[2:0]] : 1'b0) == on_q;
              row_q <= row_q + 1'b1;
              state_q <= S_PIX_CHK;
            end
          end else begin
            if (cnt_q >= end_q) state_q <= S_DONE;
            else begin
              if (op_q == OP_HLINE) px_q <= cnt_q[7:0];
              else py_q <= cnt_q[7:0];
              cnt_q <= cnt_q + 1'b1;
              state_q <= S_PIX_CHK;
            end
          end
        end
        S_FRD: state_q <= S_FWAIT;
        S_FWAIT: begin
          fdata_q <= (32'(faddr_q) < FONT_BYTES) ? font_rd : 8'd0;
          state_q <= S_NEXT;
        end
        S_DONE: begin
          read_data_o <= rdata_q;
          ignored_o <= ign_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_q != S_IDLE);

  // A result comes only out of the final state.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_DONE) else $error("stray result");
  // An accepted command always makes the block busy next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command lost");
  // Frame writes never go past the framebuffer.
  a_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr |-> 32'(req.addr) < FrameBytes) else $error("frame write out of range");

endmodule
